@@ sv/fasta_sequence_cleaner_core_assert.svh @@
// ----------------------------------------------------------------------------
// FASTA sequence cleaner assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FASTA_SEQUENCE_CLEANER_CORE_ASSERT_SVH
`define FASTA_SEQUENCE_CLEANER_CORE_ASSERT_SVH

// same-cycle implication
`define FSCL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fscl assertion failed");

// next-cycle implication
`define FSCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fscl assertion failed");

`endif

@@ sv/fscl_pkg.sv @@
// ----------------------------------------------------------------------------
// fscl_pkg
// Types, character codes and helpers for the FASTA sequence cleaner.
// ----------------------------------------------------------------------------
package fscl_pkg;

  localparam int COUNT_WIDTH = 40;
  localparam int FIELD_WIDTH = 40;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;
  typedef logic [6:0]             base_t;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_GT  = 8'h3E;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_C   = 8'h43;
  localparam logic [7:0] CHAR_G   = 8'h47;
  localparam logic [7:0] CHAR_T   = 8'h54;

  localparam logic KIND_BASE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // per-byte decode
  typedef struct packed {
    logic  nul;
    logic  eol;
    logic  hdr_close;
    logic  hdr_open;
    logic  ws;
    logic  emit;
    logic  replace;
    base_t base;
  } cls_t;

  typedef struct packed {
    logic   kind;
    base_t  base;
    field_t seq_len;
    field_t repl;
    field_t hdr;
    field_t ws;
    field_t nul;
    logic   empty;
  } res_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + cnt_t'(1);
  endfunction

  function automatic field_t to_field(input cnt_t c);
    return field_t'(c);
  endfunction

endpackage

@@ sv/fscl_classify.sv @@
// ----------------------------------------------------------------------------
// fscl_classify
// Decodes one file byte against the header and line-start flags.
// ----------------------------------------------------------------------------
module fscl_classify import fscl_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic       header_flag,
  input  logic       line_start_flag,
  output cls_t       cls
);

  logic nul;
  logic eol;
  logic open_hdr;
  logic space;
  logic acgt;

  assign nul      = (data_byte == CHAR_NUL);
  assign eol      = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);
  assign open_hdr = !nul && !header_flag && line_start_flag && (data_byte == CHAR_GT);
  assign space    = !nul && !header_flag && !open_hdr &&
                    ((data_byte == CHAR_SP) ||
                     ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR)));
  assign acgt     = (data_byte == CHAR_A) || (data_byte == CHAR_C) ||
                    (data_byte == CHAR_G) || (data_byte == CHAR_T);

  always_comb begin
    cls.nul       = nul;
    cls.eol       = eol;
    // NUL inside a header is only counted, it does not close the header
    cls.hdr_close = !nul && header_flag && eol;
    cls.hdr_open  = open_hdr;
    cls.ws        = space;
    cls.emit      = !nul && !header_flag && !open_hdr && !space;
    cls.replace   = cls.emit && !acgt;
    cls.base      = acgt ? data_byte[6:0] : CHAR_A[6:0];
  end

endmodule

@@ sv/fasta_sequence_cleaner_core.sv @@
// ----------------------------------------------------------------------------
// fasta_sequence_cleaner_core
// Strips headers, whitespace and NULs from FASTA bytes, emits cleaned bases
// and an end-of-file summary of saturating counts.
// ----------------------------------------------------------------------------
// Output: a result is registered in the output register when its byte is
//   accepted, or in the skid entry while that register is full and stalled.
// Throughput: one byte per cycle while in_stall is low; the two-entry output
//   register/skid pair takes a byte every cycle while results drain. in_stall
//   is high only while the skid entry is full.
// Reset: flags and counters return to file-start values, both result
//   entries empty. An end-of-file item resets the flags and counters after its summary.
module fasta_sequence_cleaner_core import fscl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [6:0] base_char,
  output logic [FIELD_WIDTH-1:0] base_total,
  output logic [FIELD_WIDTH-1:0] replaced_total,
  output logic [FIELD_WIDTH-1:0] header_lines,
  output logic [FIELD_WIDTH-1:0] whitespace_count,
  output logic [FIELD_WIDTH-1:0] nul_count,
  output logic       empty_error
);

  logic line_start_flag;
  logic header_flag;
  cnt_t base_counter;
  cnt_t replace_counter;
  cnt_t header_counter;
  cnt_t space_counter;
  cnt_t zero_byte_counter;

  cls_t cls;
  res_t res_new;
  res_t out_q;
  res_t skid_q;
  logic skid_valid;
  logic accept;
  logic push;
  logic pop;
  logic out_is_acgt;

  fscl_classify u_classify (
    .data_byte       (data_byte),
    .header_flag     (header_flag),
    .line_start_flag (line_start_flag),
    .cls             (cls)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (end_of_file || cls.emit);
  assign pop      = out_valid && !out_stall;

  always_comb begin
    res_new = '0;
    if (end_of_file) begin
      res_new.kind    = KIND_SUMMARY;
      res_new.seq_len = to_field(base_counter);
      res_new.repl    = to_field(replace_counter);
      res_new.hdr     = to_field(header_counter);
      res_new.ws      = to_field(space_counter);
      res_new.nul     = to_field(zero_byte_counter);
      res_new.empty   = (base_counter == '0);
    end else begin
      res_new.kind = KIND_BASE;
      res_new.base = cls.base;
    end
  end

  // file state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_start_flag   <= 1'b1;
      header_flag       <= 1'b0;
      base_counter      <= '0;
      replace_counter   <= '0;
      header_counter    <= '0;
      space_counter     <= '0;
      zero_byte_counter <= '0;
    end else if (accept) begin
      if (end_of_file) begin
        line_start_flag   <= 1'b1;
        header_flag       <= 1'b0;
        base_counter      <= '0;
        replace_counter   <= '0;
        header_counter    <= '0;
        space_counter     <= '0;
        zero_byte_counter <= '0;
      end else begin
        if (cls.nul) zero_byte_counter <= sat_inc(zero_byte_counter);
        if (cls.hdr_close) begin
          header_flag     <= 1'b0;
          line_start_flag <= 1'b1;
        end
        if (cls.hdr_open) begin
          header_flag    <= 1'b1;
          header_counter <= sat_inc(header_counter);
        end
        if (cls.ws) begin
          space_counter <= sat_inc(space_counter);
          if (cls.eol) line_start_flag <= 1'b1;
        end
        if (cls.emit) begin
          line_start_flag <= 1'b0;
          base_counter    <= sat_inc(base_counter);
          if (cls.replace) replace_counter <= sat_inc(replace_counter);
        end
      end
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign result_kind      = out_q.kind;
  assign base_char        = out_q.base;
  assign base_total       = out_q.seq_len;
  assign replaced_total   = out_q.repl;
  assign header_lines     = out_q.hdr;
  assign whitespace_count = out_q.ws;
  assign nul_count        = out_q.nul;
  assign empty_error      = out_q.empty;

  assign out_is_acgt = (base_char == CHAR_A[6:0]) || (base_char == CHAR_C[6:0]) ||
                       (base_char == CHAR_G[6:0]) || (base_char == CHAR_T[6:0]);

`include "fasta_sequence_cleaner_core_assert.svh"

  `FSCL_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid)
  `FSCL_ASSERT_IMPL(a_hdr_at_line_start, header_flag, line_start_flag)
  `FSCL_ASSERT_IMPL(a_base_is_acgt, out_valid && (result_kind == KIND_BASE), out_is_acgt)
  `FSCL_ASSERT_NEXT(a_eof_clears, accept && end_of_file, (base_counter == '0) && !header_flag)

endmodule

@@ tb/fasta_sequence_cleaner_core_test.sv @@
// ----------------------------------------------------------------------------
// fasta_sequence_cleaner_core_test
// Drives FASTA byte streams into the cleaner and checks every base and
// end-of-file summary against a cycle-free model of the filter or typed rows:
// a directed table first, then random files under changing idle/stall patterns.
// ----------------------------------------------------------------------------
module fasta_sequence_cleaner_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fscl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 233;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte = 8'h00;
  logic                   end_of_file = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   result_kind;
  logic [6:0]             base_char;
  logic [FIELD_WIDTH-1:0] base_total;
  logic [FIELD_WIDTH-1:0] replaced_total;
  logic [FIELD_WIDTH-1:0] header_lines;
  logic [FIELD_WIDTH-1:0] whitespace_count;
  logic [FIELD_WIDTH-1:0] nul_count;
  logic                   empty_error;

  fasta_sequence_cleaner_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .end_of_file      (end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .base_char        (base_char),
    .base_total       (base_total),
    .replaced_total   (replaced_total),
    .header_lines     (header_lines),
    .whitespace_count (whitespace_count),
    .nul_count        (nul_count),
    .empty_error      (empty_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter state, file-start values
  logic line_start = 1'b1;
  logic in_header  = 1'b0;
  cnt_t n_bases    = '0;
  cnt_t n_repl     = '0;
  cnt_t n_hdr      = '0;
  cnt_t n_ws       = '0;
  cnt_t n_nul      = '0;

  res_t pending_results[$];
  int   err_count = 0;
  int   result_index = 0;
  int   sent_items = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 12;
  int   recv_stall_pct = 85;

  typedef struct {
    logic [7:0] byte_val;
    logic       eof;
    logic       typed;
    res_t       want;
  } step_row_t;

  step_row_t stim_tab[$];

  function automatic void add_row(input logic [7:0] b, input logic eof,
                                  input logic typed, input res_t want);
    step_row_t row;
    row.byte_val = b;
    row.eof      = eof;
    row.typed    = typed;
    row.want     = want;
    stim_tab.insert(stim_tab.size(), row);
  endfunction

  function automatic cnt_t bump_sat(input cnt_t c);
    if (c == {COUNT_WIDTH{1'b1}}) return c;
    return c + cnt_t'(1);
  endfunction

  // one byte through the filter; returns 1 when it yields a result
  function automatic logic clean_byte(input logic [7:0] b, input logic eof,
                                      output res_t r);
    logic eol;
    r = '0;
    if (eof) begin
      r.kind    = KIND_SUMMARY;
      r.seq_len = n_bases;
      r.repl    = n_repl;
      r.hdr     = n_hdr;
      r.ws      = n_ws;
      r.nul     = n_nul;
      r.empty   = (n_bases == '0);
      line_start = 1'b1;
      in_header  = 1'b0;
      n_bases = '0;
      n_repl  = '0;
      n_hdr   = '0;
      n_ws    = '0;
      n_nul   = '0;
      return 1'b1;
    end
    if (b == CHAR_NUL) begin
      n_nul = bump_sat(n_nul);
      return 1'b0;
    end
    eol = (b == CHAR_LF) || (b == CHAR_CR);
    if (in_header) begin
      // terminator is not whitespace here
      if (eol) begin
        in_header  = 1'b0;
        line_start = 1'b1;
      end
      return 1'b0;
    end
    if (line_start && b == CHAR_GT) begin
      in_header = 1'b1;
      n_hdr     = bump_sat(n_hdr);
      return 1'b0;
    end
    if (b == CHAR_SP || (b >= CHAR_TAB && b <= CHAR_CR)) begin
      n_ws = bump_sat(n_ws);
      if (eol) line_start = 1'b1;
      return 1'b0;
    end
    line_start = 1'b0;
    r.kind = KIND_BASE;
    if (b == CHAR_A || b == CHAR_C || b == CHAR_G || b == CHAR_T) begin
      r.base = b[6:0];
    end else begin
      r.base = CHAR_A[6:0];
      n_repl = bump_sat(n_repl);
    end
    n_bases = bump_sat(n_bases);
    return 1'b1;
  endfunction

  function automatic res_t base_of(input logic [7:0] b);
    res_t r;
    r = '0;
    r.kind = KIND_BASE;
    r.base = b[6:0];
    return r;
  endfunction

  function automatic res_t summary_of(input longint seq, input longint repl,
                                      input longint hdr, input longint ws,
                                      input longint nul, input logic empty);
    res_t r;
    r = '0;
    r.kind    = KIND_SUMMARY;
    r.seq_len = field_t'(seq);
    r.repl    = field_t'(repl);
    r.hdr     = field_t'(hdr);
    r.ws      = field_t'(ws);
    r.nul     = field_t'(nul);
    r.empty   = empty;
    return r;
  endfunction

  task automatic send(input logic [7:0] b, input logic eof = 1'b0,
                      input logic typed = 1'b0, input res_t want = '0);
    res_t predicted;
    logic has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_file <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transaction accepted at this edge
    has_res = clean_byte(b, eof, predicted);
    if (has_res)
      pending_results.insert(pending_results.size(), typed ? want : predicted);
    sent_items++;
  endtask

  task automatic send_line_end();
    case ($urandom_range(2))
      0: send(CHAR_LF);
      1: send(CHAR_CR);
      default: begin
        send(CHAR_CR);
        send(CHAR_LF);
      end
    endcase
  endtask

  function automatic logic [7:0] seq_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 72) begin
      case ($urandom_range(3))
        0: return CHAR_A;
        1: return CHAR_C;
        2: return CHAR_G;
        default: return CHAR_T;
      endcase
    end
    if (roll < 80) begin
      case ($urandom_range(5))
        0: return 8'h61;   // a
        1: return 8'h63;   // c
        2: return 8'h67;   // g
        3: return 8'h74;   // t
        4: return 8'h6E;   // n
        default: return 8'h4E;   // N
      endcase
    end
    if (roll < 88) begin
      case ($urandom_range(3))
        0: return CHAR_SP;
        1: return CHAR_TAB;
        2: return CHAR_VT;
        default: return CHAR_FF;
      endcase
    end
    if (roll < 92) return CHAR_NUL;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_file();
    int         n_lines;
    int         roll;
    logic [7:0] b;
    n_lines = $urandom_range(1, 5);
    repeat (n_lines) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        // blanks before '>' keep the line start
        if ($urandom_range(9) == 0) send(CHAR_SP);
        send(CHAR_GT);
        repeat ($urandom_range(12)) begin
          b = 8'($urandom_range(255));
          if ($urandom_range(3) != 0) b = 8'($urandom_range(32, 126));
          send(b);
        end
        send_line_end();
      end else if (roll < 88) begin
        repeat ($urandom_range(16)) send(seq_byte());
        if ($urandom_range(4) != 0) send_line_end();
      end else begin
        repeat ($urandom_range(1, 8)) send(8'($urandom_range(255)));
      end
    end
    send(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             result_index, what, got, exp);
    err_count++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    res_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(result_kind), 'x);
      end else begin
        exp = pending_results.pop_front();
        if (result_kind !== exp.kind)
          report_mismatch("result_kind", 64'(result_kind), 64'(exp.kind));
        if (base_char !== exp.base)
          report_mismatch("base_char", 64'(base_char), 64'(exp.base));
        if (base_total !== exp.seq_len)
          report_mismatch("base_total", 64'(base_total), 64'(exp.seq_len));
        if (replaced_total !== exp.repl)
          report_mismatch("replaced_total", 64'(replaced_total), 64'(exp.repl));
        if (header_lines !== exp.hdr)
          report_mismatch("header_lines", 64'(header_lines), 64'(exp.hdr));
        if (whitespace_count !== exp.ws)
          report_mismatch("whitespace_count", 64'(whitespace_count), 64'(exp.ws));
        if (nul_count !== exp.nul)
          report_mismatch("nul_count", 64'(nul_count), 64'(exp.nul));
        if (empty_error !== exp.empty)
          report_mismatch("empty_error", 64'(empty_error), 64'(exp.empty));
      end
      result_index++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fasta_sequence_cleaner_core_test failed");
    $finish;
  end

  initial begin
    // summary right after reset, then headers, bases, whitespace, NULs
    add_row(8'h00, 1'b1, 1'b1, summary_of(0, 0, 0, 0, 0, 1'b1));
    add_row(CHAR_GT, 1'b0, 1'b0, '0);
    add_row(8'h78, 1'b0, 1'b0, '0);
    add_row(CHAR_NUL, 1'b0, 1'b0, '0);   // NUL keeps header open
    add_row(CHAR_LF, 1'b0, 1'b0, '0);
    add_row(CHAR_A, 1'b0, 1'b1, base_of(CHAR_A));
    add_row(CHAR_C, 1'b0, 1'b1, base_of(CHAR_C));
    add_row(CHAR_G, 1'b0, 1'b1, base_of(CHAR_G));
    add_row(CHAR_T, 1'b0, 1'b1, base_of(CHAR_T));
    add_row(8'hFF, 1'b0, 1'b1, base_of(CHAR_A));
    add_row(8'h01, 1'b0, 1'b1, base_of(CHAR_A));
    add_row(CHAR_GT, 1'b0, 1'b1, base_of(CHAR_A));  // mid-line '>'
    add_row(CHAR_NUL, 1'b0, 1'b0, '0);
    add_row(CHAR_SP, 1'b0, 1'b0, '0);
    add_row(CHAR_TAB, 1'b0, 1'b0, '0);
    add_row(CHAR_VT, 1'b0, 1'b0, '0);
    add_row(CHAR_FF, 1'b0, 1'b0, '0);
    add_row(CHAR_CR, 1'b0, 1'b0, '0);
    add_row(CHAR_SP, 1'b0, 1'b0, '0);
    add_row(CHAR_GT, 1'b0, 1'b0, '0);
    add_row(CHAR_CR, 1'b0, 1'b0, '0);     // closes header only
    add_row(8'h61, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, summary_of(8, 4, 2, 6, 2, 1'b0));
    add_row(CHAR_A, 1'b1, 1'b1, summary_of(0, 0, 0, 0, 0, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_tab[i])
      send(stim_tab[i].byte_val, stim_tab[i].eof, stim_tab[i].typed, stim_tab[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      int phase_goal;
      case (phase)
        0: begin
          send_idle_pct  = 12;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 12;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_goal = sent_items + PHASE_ITEMS;
      while (sent_items < phase_goal) send_random_file();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("fasta_sequence_cleaner_core_test passed");
    end else begin
      $display("fasta_sequence_cleaner_core_test failed");
    end
    $finish;
  end

endmodule
